[design/jhbs_pkg.sv]
// Shared types and constants for the JPEG header/body splitter.
// Standalone package; used by jpeg_header_body_splitter.
`default_nettype none

package jhbs_pkg;

  // Parser phase codes
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LEN_HI = 3'd1;
  localparam logic [2:0] PH_LEN_LO = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_SCAN   = 3'd4;
  localparam logic [2:0] PH_ERROR  = 3'd5;

  // Result channel codes
  localparam logic [1:0] CH_HEADER = 2'd0;
  localparam logic [1:0] CH_BODY   = 2'd1;
  localparam logic [1:0] CH_STATUS = 2'd2;

  // Parse status codes
  localparam logic [1:0] ST_RUNNING = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  // Marker bytes
  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_STUFF  = 8'h00;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [3:0] MK_RST_HI = 4'hD;
  localparam logic [3:0] MK_RST_MAX_LO = 4'h7;

  // Register indexes
  localparam logic REG_HEADER_ENABLE = 1'b0;
  localparam logic REG_SAFE_MODE     = 1'b1;

  // Result queue
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_PTR_W = 2;
  localparam int unsigned RQ_CNT_W = 3;

  typedef struct packed {
    logic [1:0]  channel;
    logic [7:0]  data;
    logic        last;
    logic [15:0] rcount;
    logic [1:0]  status;
  } res_t;

  function automatic logic is_restart(input logic [7:0] x);
    return (x[7:4] == MK_RST_HI) && (x[3:0] <= MK_RST_MAX_LO);
  endfunction

endpackage

`default_nettype wire

[design/jpeg_header_body_splitter.sv]
// JPEG header/body splitter: marker-segment parser with a four-entry result queue.
// Depends on jhbs_pkg.
`default_nettype none

// Takes one stream byte per beat and parses it in the same cycle against the
// parser state; the zero to two result beats it causes are written into a
// four-entry result queue; results leave one per cycle while out_ready is high.
// A new byte is taken whenever the queue has at least two free entries (decided
// from the registered fill count), so the block sustains one byte per cycle while
// bytes give at most one result each and out_ready stays high; a marker other
// than EOI or a kept FF pair can give two results, which the queue absorbs. A beat's
// results are registered in the queue before they reach the output. Configuration
// writes are taken on the APB port at any time, pready is always high.
module jpeg_header_body_splitter #(
  parameter int RST_COUNT_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_stream,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_channel,
  output logic [7:0]       out_byte,
  output logic             out_run_last,
  output logic [15:0]      out_restart_count,
  output logic [1:0]       out_parse_status,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int W = RST_COUNT_WIDTH;

  // ---------------- configuration ----------------
  logic hdr_en_r;
  logic safe_r;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_en_r <= 1'b1;
      safe_r   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        jhbs_pkg::REG_HEADER_ENABLE: hdr_en_r <= cfg_pwdata[0];
        jhbs_pkg::REG_SAFE_MODE:     safe_r   <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[2])
      jhbs_pkg::REG_HEADER_ENABLE: cfg_prdata[0] = hdr_en_r;
      jhbs_pkg::REG_SAFE_MODE:     cfg_prdata[0] = safe_r;
      default: cfg_prdata = '0;
    endcase
  end

  // ---------------- parser state ----------------
  logic [2:0]  phase_r, phase_nxt;
  logic        prev_ff_r, prev_ff_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic        is_scan_r, is_scan_nxt;
  logic [W-1:0] rcnt_r, rcnt_nxt;
  logic        err_r, err_nxt;

  logic        in_fire;
  logic [7:0]  x;
  logic        eos;

  // raw emit candidates (before header gating)
  logic        c0_v, c1_v;
  logic [1:0]  c0_ch, c1_ch;
  logic [7:0]  c0_b, c1_b;
  logic        k0, k1;
  logic        new_err;
  logic [1:0]  status;
  logic        scan_new;
  logic [1:0]  seg_ch;
  logic [15:0] len;
  logic [15:0] rem_dec;
  logic [15:0] shown;

  // results after gating and compaction
  logic [1:0]  push_n;
  jhbs_pkg::res_t r0, r1;

  assign x   = in_data_byte;
  assign eos = in_end_of_stream;
  assign in_fire = in_valid & in_ready;
  assign len = {len_hi_r, x};
  assign rem_dec = remain_r - 16'd1;

  always_comb begin
    phase_nxt   = phase_r;
    prev_ff_nxt = prev_ff_r;
    len_hi_nxt  = len_hi_r;
    remain_nxt  = remain_r;
    is_scan_nxt = is_scan_r;
    rcnt_nxt    = rcnt_r;
    err_nxt     = err_r;
    new_err     = 1'b0;
    c0_v = 1'b0; c0_ch = jhbs_pkg::CH_HEADER; c0_b = x;
    c1_v = 1'b0; c1_ch = jhbs_pkg::CH_HEADER; c1_b = x;
    scan_new = (x == jhbs_pkg::MK_SOS);
    seg_ch = (is_scan_r && !safe_r) ? jhbs_pkg::CH_BODY : jhbs_pkg::CH_HEADER;

    case (phase_r)
      jhbs_pkg::PH_ERROR: ;
      jhbs_pkg::PH_IDLE, jhbs_pkg::PH_SCAN: begin
        if (prev_ff_r && phase_r == jhbs_pkg::PH_SCAN &&
            (x == jhbs_pkg::MK_STUFF || jhbs_pkg::is_restart(x))) begin
          // keep stuffed byte or restart pair in the body
          c0_v = 1'b1; c0_ch = jhbs_pkg::CH_BODY; c0_b = jhbs_pkg::MK_PREFIX;
          c1_v = 1'b1; c1_ch = jhbs_pkg::CH_BODY; c1_b = x;
          if (jhbs_pkg::is_restart(x) && rcnt_r != '1)
            rcnt_nxt = rcnt_r + W'(1);
          prev_ff_nxt = 1'b0;
        end else if (prev_ff_r) begin
          // marker code
          prev_ff_nxt = 1'b0;
          if (x == jhbs_pkg::MK_SOI) begin
            c0_v = 1'b1; c0_ch = jhbs_pkg::CH_HEADER; c0_b = jhbs_pkg::MK_PREFIX;
            c1_v = 1'b1; c1_ch = jhbs_pkg::CH_HEADER; c1_b = x;
            phase_nxt = jhbs_pkg::PH_IDLE;
          end else if (x == jhbs_pkg::MK_EOI) begin
            phase_nxt = jhbs_pkg::PH_IDLE;
          end else begin
            is_scan_nxt = scan_new;
            c0_v = 1'b1; c0_b = jhbs_pkg::MK_PREFIX;
            c1_v = 1'b1; c1_b = x;
            c0_ch = (scan_new && !safe_r) ? jhbs_pkg::CH_BODY : jhbs_pkg::CH_HEADER;
            c1_ch = c0_ch;
            phase_nxt = jhbs_pkg::PH_LEN_HI;
          end
        end else begin
          if (phase_r == jhbs_pkg::PH_SCAN && x != jhbs_pkg::MK_PREFIX) begin
            c0_v = 1'b1; c0_ch = jhbs_pkg::CH_BODY;
          end
          prev_ff_nxt = (x == jhbs_pkg::MK_PREFIX);
        end
      end
      jhbs_pkg::PH_LEN_HI: begin
        c0_v = 1'b1; c0_ch = seg_ch;
        len_hi_nxt = x;
        phase_nxt = jhbs_pkg::PH_LEN_LO;
      end
      jhbs_pkg::PH_LEN_LO: begin
        c0_v = 1'b1; c0_ch = seg_ch;
        if (len < 16'd2) begin
          err_nxt = 1'b1;
          new_err = 1'b1;
          phase_nxt = jhbs_pkg::PH_ERROR;
        end else begin
          remain_nxt = len - 16'd2;
          if (len == 16'd2) begin
            prev_ff_nxt = 1'b0;
            if (is_scan_r) begin
              rcnt_nxt = W'(1);
              phase_nxt = jhbs_pkg::PH_SCAN;
            end else begin
              phase_nxt = jhbs_pkg::PH_IDLE;
            end
          end else begin
            phase_nxt = jhbs_pkg::PH_DATA;
          end
        end
      end
      jhbs_pkg::PH_DATA: begin
        c0_v = 1'b1; c0_ch = seg_ch;
        remain_nxt = rem_dec;
        if (rem_dec == 16'd0) begin
          prev_ff_nxt = 1'b0;
          if (is_scan_r) begin
            rcnt_nxt = W'(1);
            phase_nxt = jhbs_pkg::PH_SCAN;
          end else begin
            phase_nxt = jhbs_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        phase_nxt = jhbs_pkg::PH_IDLE;
        prev_ff_nxt = 1'b0;
      end
    endcase

    // stream ending inside a segment or scan data
    if (eos && !err_nxt && phase_nxt != jhbs_pkg::PH_IDLE) begin
      err_nxt = 1'b1;
      new_err = 1'b1;
    end
  end

  assign status = err_nxt ? jhbs_pkg::ST_ERROR :
                  (eos ? jhbs_pkg::ST_DONE : jhbs_pkg::ST_RUNNING);

  generate
    if (W > 16) begin : g_clip
      assign shown = (|rcnt_nxt[W-1:16]) ? 16'hFFFF : rcnt_nxt[15:0];
    end else begin : g_ext
      assign shown = 16'(rcnt_nxt);
    end
  endgenerate

  // drop header beats when disabled, then pack the survivors
  assign k0 = c0_v && !(c0_ch == jhbs_pkg::CH_HEADER && !hdr_en_r);
  assign k1 = c1_v && !(c1_ch == jhbs_pkg::CH_HEADER && !hdr_en_r);

  always_comb begin
    r0 = '0;
    r1 = '0;
    r0.rcount = shown; r0.status = status;
    r1.rcount = shown; r1.status = status;
    r1.last = 1'b1;
    push_n = 2'd0;
    if (k0 && k1) begin
      r0.channel = c0_ch; r0.data = c0_b; r0.last = 1'b0;
      r1.channel = c1_ch; r1.data = c1_b;
      push_n = 2'd2;
    end else if (k0 || k1) begin
      r0.channel = k0 ? c0_ch : c1_ch;
      r0.data    = k0 ? c0_b : c1_b;
      r0.last    = 1'b1;
      push_n = 2'd1;
    end else if (eos || new_err) begin
      r0.channel = jhbs_pkg::CH_STATUS;
      r0.data    = 8'h00;
      r0.last    = 1'b1;
      push_n = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= jhbs_pkg::PH_IDLE;
      prev_ff_r <= 1'b0;
      len_hi_r  <= '0;
      remain_r  <= '0;
      is_scan_r <= 1'b0;
      rcnt_r    <= '0;
      err_r     <= 1'b0;
    end else if (in_fire) begin
      if (eos) begin
        // rearm for the next stream
        phase_r   <= jhbs_pkg::PH_IDLE;
        prev_ff_r <= 1'b0;
        len_hi_r  <= '0;
        remain_r  <= '0;
        is_scan_r <= 1'b0;
        rcnt_r    <= '0;
        err_r     <= 1'b0;
      end else begin
        phase_r   <= phase_nxt;
        prev_ff_r <= prev_ff_nxt;
        len_hi_r  <= len_hi_nxt;
        remain_r  <= remain_nxt;
        is_scan_r <= is_scan_nxt;
        rcnt_r    <= rcnt_nxt;
        err_r     <= err_nxt;
      end
    end
  end

  // ---------------- result queue ----------------
  jhbs_pkg::res_t rq_mem_r [jhbs_pkg::RQ_DEPTH];
  logic [jhbs_pkg::RQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [jhbs_pkg::RQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0] push;
  logic       pop;
  logic [jhbs_pkg::RQ_PTR_W-1:0] wr_ptr_p1;

  assign in_ready = (cnt_r <= jhbs_pkg::RQ_CNT_W'(jhbs_pkg::RQ_DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign pop  = out_valid & out_ready;
  assign push = in_fire ? push_n : 2'd0;
  assign wr_ptr_p1 = wr_ptr_r + jhbs_pkg::RQ_PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + jhbs_pkg::RQ_PTR_W'(push);
  assign rd_ptr_nxt = rd_ptr_r + jhbs_pkg::RQ_PTR_W'(pop);
  assign cnt_nxt = cnt_r + jhbs_pkg::RQ_CNT_W'(push) - jhbs_pkg::RQ_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push != 2'd0) rq_mem_r[wr_ptr_r] <= r0;
    if (push == 2'd2) rq_mem_r[wr_ptr_p1] <= r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign out_channel       = rq_mem_r[rd_ptr_r].channel;
  assign out_byte          = rq_mem_r[rd_ptr_r].data;
  assign out_run_last      = rq_mem_r[rd_ptr_r].last;
  assign out_restart_count = rq_mem_r[rd_ptr_r].rcount;
  assign out_parse_status  = rq_mem_r[rd_ptr_r].status;

endmodule

`default_nettype wire
